// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms used by the rtl of this project
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge of clk, held off during reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every rising edge of clk, held off during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/dfsr_pkg.sv
// ----------------------------------------------------------------------------
// dfsr_pkg
// shared types and constants of the decimal fixed-point square root
// ----------------------------------------------------------------------------
package dfsr_pkg;

    localparam int DEF_FRACTION_DIGITS = 3;
    localparam int DEF_INPUT_BITS      = 32;
    localparam int ROOT_W              = 26;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_ROOT,
        ST_DONE
    } dfsr_state_t;

    // control from the handshake side into the root unit
    typedef struct packed {
        logic start;
        logic take;
    } dfsr_ctl_t;

    // status from the root unit
    typedef struct packed {
        logic busy;
        logic done;
    } dfsr_stat_t;

endpackage

// File: hw/rtl/dfsr_root_unit.sv
// ----------------------------------------------------------------------------
// dfsr_root_unit
// scales a non-negative input by 100 per fraction digit, then a restoring root, 1 bit/cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dfsr_root_unit #(
    parameter int FRACTION_DIGITS = dfsr_pkg::DEF_FRACTION_DIGITS,
    parameter int INPUT_BITS      = dfsr_pkg::DEF_INPUT_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dfsr_pkg::dfsr_ctl_t           ctl,
    input  logic signed [INPUT_BITS-1:0]  value,
    output dfsr_pkg::dfsr_stat_t          stat,
    output logic [dfsr_pkg::ROOT_W-1:0]   root,
    output logic                          exact
);
    import dfsr_pkg::*;

    // radicand width: magnitude bits plus 7 bits per factor of 100, kept even
    localparam int NW_RAW = INPUT_BITS - 1 + 7 * FRACTION_DIGITS;
    localparam int NW     = NW_RAW + (NW_RAW % 2);
    localparam int RB     = NW / 2;
    localparam int RW     = RB + 3;
    localparam int SCW    = $clog2(FRACTION_DIGITS + 1) + 1;
    localparam int ITW    = $clog2(RB) + 1;

    dfsr_state_t    state_reg, state_next;
    logic [SCW-1:0] sc_cnt_reg, sc_cnt_next;
    logic [ITW-1:0] it_cnt_reg, it_cnt_next;
    logic [NW-1:0]  n_reg, n_next;
    logic [RB-1:0]  q_reg, q_next;
    logic [RW-1:0]  r_reg, r_next;
    logic           neg_reg, neg_next;

    logic [RW-1:0]  r_sh;
    logic [RW-1:0]  trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            sc_cnt_reg <= '0;
            it_cnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            sc_cnt_reg <= sc_cnt_next;
            it_cnt_reg <= it_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        neg_reg <= neg_next;
    end

    // one restoring step: bring down two radicand bits, try 4q+1
    assign r_sh  = {r_reg[RW-3:0], n_reg[NW-1:NW-2]};
    assign trial = RW'({q_reg, 2'b01});

    always_comb
    begin
        state_next  = state_reg;
        sc_cnt_next = sc_cnt_reg;
        it_cnt_next = it_cnt_reg;
        n_next      = n_reg;
        q_next      = q_reg;
        r_next      = r_reg;
        neg_next    = neg_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctl.start)
                begin
                    n_next      = NW'(value[INPUT_BITS-2:0]);
                    q_next      = '0;
                    r_next      = '0;
                    neg_next    = value[INPUT_BITS-1];
                    sc_cnt_next = '0;
                    it_cnt_next = '0;
                    if (value[INPUT_BITS-1])
                        state_next = ST_DONE;
                    else if (FRACTION_DIGITS == 0)
                        state_next = ST_ROOT;
                    else
                        state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                // n * 100 as n*64 + n*32 + n*4
                n_next      = (n_reg << 6) + (n_reg << 5) + (n_reg << 2);
                sc_cnt_next = sc_cnt_reg + 1'b1;
                if (sc_cnt_reg == SCW'(FRACTION_DIGITS - 1))
                    state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                n_next      = n_reg << 2;
                it_cnt_next = it_cnt_reg + 1'b1;
                if (r_sh >= trial)
                begin
                    r_next = r_sh - trial;
                    q_next = {q_reg[RB-2:0], 1'b1};
                end
                else
                begin
                    r_next = r_sh;
                    q_next = {q_reg[RB-2:0], 1'b0};
                end
                if (it_cnt_reg == ITW'(RB - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (ctl.take)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.done = (state_reg == ST_DONE);
    assign root      = ROOT_W'(q_reg);
    // value times a nonzero square is a square only when value is itself a square
    assign exact     = !neg_reg && (r_reg == '0);

    `ASSERT_IMPL(a_start_idle, ctl.start, state_reg == ST_IDLE,
        "start while root unit busy")
    `ASSERT_IMPL(a_take_done, ctl.take, state_reg == ST_DONE,
        "result taken before root unit done")
    `ASSERT_IMPL(a_iter_bound, state_reg == ST_ROOT, it_cnt_reg < ITW'(RB),
        "root iteration count out of range")

endmodule

// File: hw/rtl/decimal_fixed_point_square_root_core.sv
// sequence: an accepted word runs one scale step per fraction digit, then the restoring root
//   loop giving one root bit per cycle, then waits in the done state until the output register
//   takes it and raises rsp_valid; a negative word goes straight to the done state
// a new word is accepted only once the previous one has left the root unit
// ROOT_BITS = (INPUT_BITS - 1 + 7 * FRACTION_DIGITS, rounded up to even) / 2
// reset: rst_n asynchronous active low clears sequencer and output valid
// ----------------------------------------------------------------------------
// decimal_fixed_point_square_root_core
// square root of a signed word, truncated to decimal fraction digits,
// with a perfect-square flag
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module decimal_fixed_point_square_root_core #(
    parameter int FRACTION_DIGITS = dfsr_pkg::DEF_FRACTION_DIGITS,
    parameter int INPUT_BITS      = dfsr_pkg::DEF_INPUT_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic signed [INPUT_BITS-1:0]  value,
    // response channel
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [dfsr_pkg::ROOT_W-1:0]   root_thousandths,
    output logic                          exact
);
    import dfsr_pkg::*;

    dfsr_ctl_t            ctl;
    dfsr_stat_t           stat;
    logic [ROOT_W-1:0]    unit_root;
    logic                 unit_exact;

    // output register decouples the root unit from a stalled consumer
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [ROOT_W-1:0]    root_reg;
    logic                 exact_reg;
    logic                 xfer;

    // the unit holds its result in its done state until the output register
    // has room; a new word is taken only once the unit is back in idle
    assign req_stall = stat.busy;
    assign ctl.start = req_valid && !req_stall;
    assign xfer      = stat.done && (!rsp_valid_reg || !rsp_stall);
    assign ctl.take  = xfer;

    dfsr_root_unit #(
        .FRACTION_DIGITS (FRACTION_DIGITS),
        .INPUT_BITS      (INPUT_BITS)
    ) u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .value (value),
        .stat  (stat),
        .root  (unit_root),
        .exact (unit_exact)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (xfer)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    // payload loads only on transfer, so a stalled word holds
    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            root_reg  <= unit_root;
            exact_reg <= unit_exact;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign root_thousandths = root_reg;
    assign exact            = exact_reg;

    // an accepted word keeps the request side stalled in the next cycle
    `ASSERT_CLK(a_accept_busy, (req_valid && !req_stall) |=> req_stall,
        "request side not stalled after accept")
    // a finished result always lands in the output register
    `ASSERT_CLK(a_xfer_valid, xfer |=> rsp_valid,
        "transferred result not presented")
    // a stalled response word stays valid and unchanged
    `ASSERT_IMPL(a_rsp_hold, rsp_valid && rsp_stall,
        ##1 (rsp_valid && $stable(root_thousandths) && $stable(exact)),
        "stalled response word changed")

endmodule

// File: tb/tb_decimal_fixed_point_square_root_core.sv
// ----------------------------------------------------------------------------
// tb_decimal_fixed_point_square_root_core
// self-checking bench for the decimal fixed-point square root core: a queue
// of signed words is driven over the request channel, every accepted word is
// run through an exact integer root model, and each response word is checked
// field by field in order against it, with random gaps and stalls
// ----------------------------------------------------------------------------
module tb_decimal_fixed_point_square_root_core;

    import dfsr_pkg::*;

    // one expected response word
    typedef struct {
        logic [ROOT_W-1:0] root;
        logic              exact;
    } root_word_t;

    logic clk;
    logic rst_n = 1'b0;

    // request channel
    logic                req_valid = 1'b0;
    logic                req_stall;
    logic signed [31:0]  value     = '0;

    // response channel
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic [ROOT_W-1:0]   root_thousandths;
    logic                exact;

    // words waiting to be sent, and roots waiting to come back
    logic signed [31:0]  pending_words[$];
    root_word_t          expected_roots[$];

    logic req_fired = 1'b0;   // request word taken at the last rising edge
    logic no_idle   = 1'b0;   // both sides run flat out while set
    int   err_count = 0;

    decimal_fixed_point_square_root_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .value            (value),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .root_thousandths (root_thousandths),
        .exact            (exact)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // restoring integer square root, remainder returned through rem
    function automatic logic [63:0] int_sqrt(input logic [63:0] v, output logic [63:0] rem);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        rem = v;
        return r;
    endfunction

    // root in thousandths is floor(sqrt(v * 10^6)); the flag comes from the
    // remainder of the plain integer root
    function automatic root_word_t sqrt_milli(input logic signed [31:0] v);
        root_word_t  w;
        logic [63:0] rem;
        logic [63:0] r;
        if (v < 0)
        begin
            w.root  = '0;
            w.exact = 1'b0;
        end
        else
        begin
            r       = int_sqrt({32'd0, v}, rem);
            w.exact = (rem == 0);
            r       = int_sqrt({32'd0, v} * 64'd1000000, rem);
            w.root  = r[ROOT_W-1:0];
        end
        return w;
    endfunction

    // random word: full range, small, perfect squares and their neighbors,
    // negatives and large positives
    function automatic logic signed [31:0] random_word();
        logic [31:0] k;
        logic [31:0] w;
        w = '0;
        case ($urandom_range(0, 6))
            0: w = $urandom;
            1: w = $urandom_range(0, 300);
            2, 3:
            begin
                k = $urandom_range(0, 46340);
                w = k * k;
            end
            4:
            begin
                k = $urandom_range(1, 46340);
                w = ($urandom_range(0, 1) != 0) ? k * k + 1 : k * k - 1;
            end
            5: w = {1'b1, 31'($urandom)};
            default: w = {1'b0, 31'($urandom)};
        endcase
        return w;
    endfunction

    function automatic bit roll_idle();
        return !no_idle && ($urandom_range(0, 99) < 38);
    endfunction

    // driver: inputs move on the falling edge; a word stays put until taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_fired)
            begin
                if (pending_words.size() != 0 && !roll_idle())
                begin
                    req_valid <= 1'b1;
                    value     <= pending_words.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
            rsp_stall <= roll_idle();
        end
    end

    // monitor: predict on every accepted request, check every accepted response
    always @(posedge clk)
    begin
        root_word_t want;
        req_fired <= rst_n && req_valid && !req_stall;
        if (rst_n && req_valid && !req_stall)
            expected_roots.push_back(sqrt_milli(value));
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_roots.size() == 0)
            begin
                $error("response word with nothing outstanding: root_thousandths %0d exact %0d",
                       root_thousandths, exact);
                err_count++;
            end
            else
            begin
                want = expected_roots.pop_front();
                if (root_thousandths !== want.root)
                begin
                    $error("root_thousandths expected %0d actual %0d", want.root,
                           root_thousandths);
                    err_count++;
                end
                if (exact !== want.exact)
                begin
                    $error("exact expected %0d actual %0d", want.exact, exact);
                    err_count++;
                end
            end
        end
    end

    // wait until every queued word is taken and every root has come back
    task automatic drain();
        while (pending_words.size() != 0 || req_valid || expected_roots.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        // reset held low from the start, released on a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words: zero, ones, extremes, largest perfect square and
        // its neighbors, small squares and non-squares, negatives
        pending_words.push_back(32'sd0);
        pending_words.push_back(32'sd1);
        pending_words.push_back(-32'sd1);
        pending_words.push_back(32'sd2);
        pending_words.push_back(32'sd3);
        pending_words.push_back(32'sd4);
        pending_words.push_back(32'sd15);
        pending_words.push_back(32'sd16);
        pending_words.push_back(32'sd17);
        pending_words.push_back(32'sd99);
        pending_words.push_back(32'sd100);
        pending_words.push_back(32'sd999999);
        pending_words.push_back(32'sd1000000);
        pending_words.push_back(32'sd2147395599);
        pending_words.push_back(32'sd2147395600);
        pending_words.push_back(32'sd2147395601);
        pending_words.push_back(32'sh7fffffff);
        pending_words.push_back(32'sh80000000);
        pending_words.push_back(32'sh40000000);
        pending_words.push_back(32'sh55555555);
        pending_words.push_back(32'shaaaaaaaa);
        pending_words.push_back(32'sh3fffffff);

        // sender holds off until the pipe is empty before the random part
        drain();

        repeat (600) pending_words.push_back(random_word());
        drain();

        // long stretch with no gaps and no stalls on either side
        no_idle = 1'b1;
        repeat (350) pending_words.push_back(random_word());
        drain();
        no_idle = 1'b0;

        repeat (500) pending_words.push_back(random_word());
        drain();

        // a little slack for any stray response word
        repeat (40) @(posedge clk);
        if (err_count == 0)
            $display("tb_decimal_fixed_point_square_root_core: clean");
        else
            $display("tb_decimal_fixed_point_square_root_core: errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #10000000;
        $display("tb_decimal_fixed_point_square_root_core: errors");
        $finish;
    end

endmodule
